@@ src/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ src/osavg_pkg.sv @@
package osavg_pkg;

   // fixed field widths
   localparam int SAMPLE_W    = 12;
   localparam int COUNT_W     = 16;
   localparam int CHAN_W      = 4;
   localparam int AVG_OUT_W   = 12;
   localparam int SUM_W       = 18;
   localparam int BIT_W       = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W   = 2;

   // input word modes
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_CONV  = 2'd1,
      MODE_START = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHANNEL_COUNT = 2'd0,
      REG_SAMPLES_AVG   = 2'd1
   } reg_index_type;

   // status flags carried in every result word
   typedef struct packed {
      logic started;
      logic sampling;
      logic too_fast;
      logic unstoppable;
      logic overflow;
   } flags_type;

endpackage

@@ src/oversampling_adc_scan_averager_unit.sv @@
// Status word: registered, valid in the cycle after the input word is taken; one word per
// cycle while the receiver does not stall. Completing sample: per channel a load, then the
// bit-serial divider over all SUM_W dividend bits, then an average word once output is free.
// Input is stalled while averages are produced or while a full output register is stalled.
// Reset (synchronous, active high) clears flags, counters, sum valid bits and the output
// valid bit; channel_count and samples_to_average return to 1.
`include "assert_macros.svh"

module oversampling_adc_scan_averager_unit
   import osavg_pkg::*;
#(
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_AVERAGE  = 64,
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1),
   localparam int AVG_W = $clog2(MAX_AVERAGE + 1),
   localparam int PTR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int CFG_W = (CNT_W > AVG_W) ? CNT_W : AVG_W
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   // input words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [SAMPLE_W-1:0]   req_conversion_value,
   input  logic [COUNT_W-1:0]    req_sample_count,
   input  logic                  req_buffer_room,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_kind,
   output logic [CHAN_W-1:0]     rsp_channel,
   output logic [AVG_OUT_W-1:0]  rsp_average,
   output logic                  rsp_last,
   output logic                  rsp_accepted,
   output logic                  rsp_started,
   output logic                  rsp_sampling,
   output logic                  rsp_too_fast,
   output logic                  rsp_unstoppable,
   output logic                  rsp_overflow
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } state_type;

   // control state
   state_type             state_ff, state_in;
   flags_type             flags_ff, flags_in;
   logic [COUNT_W-1:0]    remaining_ff, remaining_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [AVG_W-1:0]      pass_ff, pass_in;
   logic [CNT_W-1:0]      chan_cnt_ff, chan_cnt_in;
   logic [AVG_W-1:0]      avg_cnt_ff, avg_cnt_in;
   logic [PTR_W-1:0]      ch_ff, ch_in;
   logic [BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [MAX_CHANNELS-1:0] valid_ff, valid_in;

   // divider shift registers
   logic [SUM_W-1:0]      dvd_ff, dvd_in;
   logic [AVG_W-1:0]      rem_ff, rem_in;

   // channel sums
   logic [SUM_W-1:0]      sum_ff [MAX_CHANNELS];
   logic                  sum_we;
   logic [PTR_W-1:0]      sum_waddr;
   logic [SUM_W-1:0]      sum_wdata;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [CHAN_W-1:0]     rsp_channel_ff, rsp_channel_in;
   logic [AVG_OUT_W-1:0]  rsp_average_ff, rsp_average_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   flags_type             rsp_flags_ff, rsp_flags_in;

   // helpers
   logic                  out_free;
   logic                  take;
   logic [PTR_W-1:0]      rd_idx;
   logic [SUM_W-1:0]      rd_sum;
   logic [CNT_W-1:0]      ptr_next;
   logic [AVG_W-1:0]      pass_next;
   logic [CNT_W-1:0]      ch_next;
   logic [AVG_W:0]        trial;
   logic                  q_bit;
   logic [COUNT_W-1:0]    rem_dec;
   logic                  stop;
   logic                  accepted;
   logic                  load_status;
   logic                  cfg_ok;
   logic                  start_idle;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign take      = req_valid && !req_stall;

   // one read port on the sums: scan position while idle, output channel otherwise
   assign rd_idx = (state_ff == ST_IDLE) ? ptr_ff : ch_ff;
   assign rd_sum = valid_ff[rd_idx] ? sum_ff[rd_idx] : '0;

   assign ptr_next  = CNT_W'(ptr_ff) + CNT_W'(1);
   assign pass_next = pass_ff + AVG_W'(1);
   assign ch_next   = CNT_W'(ch_ff) + CNT_W'(1);

   // one restoring-division step per cycle
   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign q_bit = trial >= {1'b0, avg_cnt_ff};

   always_comb begin
      state_in        = state_ff;
      flags_in        = flags_ff;
      remaining_in    = remaining_ff;
      ptr_in          = ptr_ff;
      pass_in         = pass_ff;
      chan_cnt_in     = chan_cnt_ff;
      avg_cnt_in      = avg_cnt_ff;
      ch_in           = ch_ff;
      bit_cnt_in      = bit_cnt_ff;
      valid_in        = valid_ff;
      dvd_in          = dvd_ff;
      rem_in          = rem_ff;
      sum_we          = 1'b0;
      sum_waddr       = ptr_ff;
      sum_wdata       = rd_sum + SUM_W'(req_conversion_value);
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_kind_in     = rsp_kind_ff;
      rsp_channel_in  = rsp_channel_ff;
      rsp_average_in  = rsp_average_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_flags_in    = rsp_flags_ff;
      rem_dec         = (remaining_ff != '0) ? remaining_ff - COUNT_W'(1) : '0;
      stop            = 1'b0;
      accepted        = 1'b1;
      load_status     = 1'b0;
      cfg_ok          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               load_status = 1'b1;
               unique case (mode_type'(req_mode))
                  MODE_TICK: begin
                     if (flags_ff.started) begin
                        if (flags_ff.sampling) begin
                           flags_in.too_fast = 1'b1;
                           flags_in.started  = 1'b0;
                           flags_in.sampling = 1'b0;
                        end else begin
                           flags_in.sampling = 1'b1;
                           valid_in          = '0;
                           ptr_in            = '0;
                           pass_in           = '0;
                        end
                     end
                  end
                  MODE_CONV: begin
                     if (flags_ff.sampling && flags_ff.started) begin
                        sum_we            = 1'b1;
                        valid_in[ptr_ff]  = 1'b1;
                        if (ptr_next >= chan_cnt_ff) begin
                           ptr_in = '0;
                           if (pass_next >= avg_cnt_ff) begin
                              // sample complete
                              pass_in = '0;
                              if (req_buffer_room) begin
                                 remaining_in = rem_dec;
                                 stop = !flags_ff.unstoppable && (rem_dec == '0);
                              end else begin
                                 flags_in.overflow = 1'b1;
                                 stop = 1'b1;
                              end
                              flags_in.sampling = 1'b0;
                              if (stop) begin
                                 remaining_in     = '0;
                                 flags_in.started = 1'b0;
                              end
                              if (req_buffer_room) begin
                                 load_status = 1'b0;
                                 ch_in       = '0;
                                 state_in    = ST_LOAD;
                              end
                           end else begin
                              pass_in = pass_next;
                           end
                        end else begin
                           ptr_in = PTR_W'(ptr_next);
                        end
                     end
                  end
                  MODE_START: begin
                     if (flags_ff.started) begin
                        accepted = 1'b0;
                     end else begin
                        flags_in.unstoppable = (req_sample_count == '0);
                        remaining_in         = req_sample_count;
                        flags_in.started     = 1'b1;
                        flags_in.sampling    = 1'b0;
                        flags_in.overflow    = 1'b0;
                        ptr_in               = '0;
                        pass_in              = '0;
                     end
                  end
                  MODE_STOP: begin
                     if (flags_ff.started) begin
                        flags_in.started  = 1'b0;
                        flags_in.sampling = 1'b0;
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            dvd_in     = rd_sum;
            rem_in     = '0;
            bit_cnt_in = BIT_W'(SUM_W);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in     = q_bit ? AVG_W'(trial - {1'b0, avg_cnt_ff}) : AVG_W'(trial);
            dvd_in     = {dvd_ff[SUM_W-2:0], q_bit};
            bit_cnt_in = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == BIT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = 1'b1;
               rsp_channel_in  = CHAN_W'(ch_ff);
               rsp_average_in  = dvd_ff[AVG_OUT_W-1:0];
               rsp_last_in     = (ch_next == chan_cnt_ff);
               rsp_accepted_in = 1'b1;
               rsp_flags_in    = flags_ff;
               if (ch_next == chan_cnt_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = PTR_W'(ch_next);
                  state_in = ST_LOAD;
               end
            end
         end
      endcase

      // status word for everything that does not produce averages
      if (load_status) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = 1'b0;
         rsp_channel_in  = '0;
         rsp_average_in  = '0;
         rsp_last_in     = 1'b1;
         rsp_accepted_in = accepted;
         rsp_flags_in    = flags_in;
      end

      // configuration write, only taken while stopped and in range
      if (csr_we && !flags_ff.started) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: begin
               cfg_ok = (csr_wdata != '0) && (csr_wdata <= CFG_W'(MAX_CHANNELS));
               if (cfg_ok) begin
                  chan_cnt_in = CNT_W'(csr_wdata);
               end
            end
            REG_SAMPLES_AVG: begin
               cfg_ok = (csr_wdata != '0) && (csr_wdata <= CFG_W'(MAX_AVERAGE));
               if (cfg_ok) begin
                  avg_cnt_in = AVG_W'(csr_wdata);
               end
            end
            default: cfg_ok = 1'b0;
         endcase
         if (cfg_ok) begin
            flags_in = '0;
            valid_in = '0;
            ptr_in   = '0;
            pass_in  = '0;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         remaining_ff <= '0;
         ptr_ff       <= '0;
         pass_ff      <= '0;
         chan_cnt_ff  <= CNT_W'(1);
         avg_cnt_ff   <= AVG_W'(1);
         ch_ff        <= '0;
         bit_cnt_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         remaining_ff <= remaining_in;
         ptr_ff       <= ptr_in;
         pass_ff      <= pass_in;
         chan_cnt_ff  <= chan_cnt_in;
         avg_cnt_ff   <= avg_cnt_in;
         ch_ff        <= ch_in;
         bit_cnt_ff   <= bit_cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvd_ff          <= dvd_in;
      rem_ff          <= rem_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_average_ff  <= rsp_average_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_flags_ff    <= rsp_flags_in;
   end

   // sum storage, one write per cycle
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_ff[sum_waddr] <= sum_wdata;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_channel     = rsp_channel_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_started     = rsp_flags_ff.started;
   assign rsp_sampling    = rsp_flags_ff.sampling;
   assign rsp_too_fast    = rsp_flags_ff.too_fast;
   assign rsp_unstoppable = rsp_flags_ff.unstoppable;
   assign rsp_overflow    = rsp_flags_ff.overflow;

   // start taken while stopped, no register write alongside
   assign start_idle = take && (req_mode == MODE_START) && !flags_ff.started && !csr_we;

   // checks
   `ASSERT_IMPL(a_sampling_needs_started, clock, reset, flags_ff.sampling, flags_ff.started)
   `ASSERT_IMPL(a_ptr_in_scan, clock, reset, 1'b1, CNT_W'(ptr_ff) < chan_cnt_ff)
   `ASSERT_IMPL(a_div_rem_below, clock, reset, state_ff == ST_DIV, rem_ff < avg_cnt_ff)
   `ASSERT_IMPL(a_status_is_last, clock, reset, rsp_valid_ff && !rsp_kind_ff, rsp_last_ff)
   `ASSERT_NEXT(a_start_arms, clock, reset, start_idle, flags_ff.started && !flags_ff.overflow)

endmodule

@@ dv/scan_average_checker.sv @@
// Watches the configuration port and both word channels of the scan averager,
// predicts the result words and compares them in order.
module scan_average_checker
   import osavg_pkg::*;
#(
   parameter int MAX_CH  = 16,
   parameter int MAX_AVG = 64,
   parameter int WDATA_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WDATA_W-1:0]    csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [SAMPLE_W-1:0]   req_conversion_value,
   input  logic [COUNT_W-1:0]    req_sample_count,
   input  logic                  req_buffer_room,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_kind,
   input  logic [CHAN_W-1:0]     rsp_channel,
   input  logic [AVG_OUT_W-1:0]  rsp_average,
   input  logic                  rsp_last,
   input  logic                  rsp_accepted,
   input  logic                  rsp_started,
   input  logic                  rsp_sampling,
   input  logic                  rsp_too_fast,
   input  logic                  rsp_unstoppable,
   input  logic                  rsp_overflow,
   output int                    fail_count,
   output int                    pending,
   output int                    words_checked,
   output int                    averages_checked
);

   localparam int NCH_W = $clog2(MAX_CH + 1);
   localparam int NSC_W = $clog2(MAX_AVG + 1);

   typedef struct packed {
      logic                  kind;
      logic [CHAN_W-1:0]     channel;
      logic [AVG_OUT_W-1:0]  average;
      logic                  last;
      logic                  accepted;
      flags_type             flags;
   } scan_word_type;

   scan_word_type expected_words[$];

   // predicted block state
   logic [SUM_W-1:0]  sums [MAX_CH];
   logic [NCH_W-1:0]  chan_ptr;
   logic [NSC_W-1:0]  pass_cnt;
   logic [COUNT_W-1:0] samples_to_go;
   flags_type         status;
   logic [NCH_W-1:0]  num_channels;
   logic [NSC_W-1:0]  num_scans;

   function automatic void clear_sums();
      for (int i = 0; i < MAX_CH; i++) sums[i] = '0;
      chan_ptr = '0;
      pass_cnt = '0;
   endfunction

   function automatic void reset_model();
      num_channels  = NCH_W'(1);
      num_scans     = NSC_W'(1);
      clear_sums();
      samples_to_go = '0;
      status        = '0;
   endfunction

   // register write: ignored while armed or out of range
   function automatic void apply_write(logic [CSR_IDX_W-1:0] idx, logic [WDATA_W-1:0] val);
      if (status.started) return;
      if (idx == REG_CHANNEL_COUNT) begin
         if (val < 1 || val > MAX_CH) return;
         num_channels = NCH_W'(val);
      end else if (idx == REG_SAMPLES_AVG) begin
         if (val < 1 || val > MAX_AVG) return;
         num_scans = NSC_W'(val);
      end else begin
         return;
      end
      status = '0;
      clear_sums();
   endfunction

   function automatic void push_word(logic kind, logic [CHAN_W-1:0] ch,
                                     logic [AVG_OUT_W-1:0] avg, logic last, logic acc);
      scan_word_type w;
      w.kind     = kind;
      w.channel  = ch;
      w.average  = avg;
      w.last     = last;
      w.accepted = acc;
      w.flags    = status;
      expected_words.push_back(w);
   endfunction

   // end of a sample; returns 1 when averages were emitted
   function automatic bit finish_sample(logic room);
      logic [AVG_OUT_W-1:0] means [MAX_CH];
      bit halt;
      if (room) begin
         for (int ch = 0; ch < num_channels; ch++)
            means[ch] = AVG_OUT_W'(sums[ch] / num_scans);
         if (samples_to_go != 0) samples_to_go--;
         halt = !status.unstoppable && samples_to_go == 0;
      end else begin
         status.overflow = 1'b1;
         halt = 1'b1;
      end
      if (halt) begin
         samples_to_go   = '0;
         status.started  = 1'b0;
         status.sampling = 1'b0;
      end else begin
         status.sampling = 1'b0;
      end
      if (room) begin
         for (int ch = 0; ch < num_channels; ch++)
            push_word(1'b1, CHAN_W'(ch), means[ch], (ch + 1 == num_channels), 1'b1);
      end
      return room;
   endfunction

   function automatic void predict_words(logic [1:0] mode, logic [SAMPLE_W-1:0] value,
                                         logic [COUNT_W-1:0] count, logic room);
      bit acc;
      bit done;
      acc  = 1'b1;
      done = 1'b0;
      case (mode_type'(mode))
         MODE_TICK: begin
            if (status.started) begin
               if (status.sampling) begin
                  status.too_fast = 1'b1;
                  status.started  = 1'b0;
                  status.sampling = 1'b0;
               end else begin
                  status.sampling = 1'b1;
                  clear_sums();
               end
            end
         end
         MODE_CONV: begin
            if (status.sampling && status.started) begin
               sums[chan_ptr[CHAN_W-1:0]] = sums[chan_ptr[CHAN_W-1:0]] + SUM_W'(value);
               chan_ptr++;
               if (chan_ptr >= num_channels) begin
                  chan_ptr = '0;
                  if (pass_cnt + 1 >= num_scans) begin
                     pass_cnt = '0;
                     done = finish_sample(room);
                  end else begin
                     pass_cnt++;
                  end
               end
            end
         end
         MODE_START: begin
            if (status.started) begin
               acc = 1'b0;
            end else begin
               status.unstoppable = (count == '0);
               samples_to_go      = count;
               status.started     = 1'b1;
               status.sampling    = 1'b0;
               status.overflow    = 1'b0;
               chan_ptr           = '0;
               pass_cnt           = '0;
            end
         end
         default: begin
            if (status.started) begin
               status.started  = 1'b0;
               status.sampling = 1'b0;
            end
         end
      endcase
      if (!done) push_word(1'b0, '0, '0, 1'b1, acc);
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_word();
      scan_word_type w;
      if (expected_words.size() == 0) begin
         $error("result word with nothing expected (kind %0d channel %0d average %0d)",
                rsp_kind, rsp_channel, rsp_average);
         fail_count++;
         return;
      end
      w = expected_words.pop_front();
      compare_field("kind", 32'(w.kind), 32'(rsp_kind));
      compare_field("channel", 32'(w.channel), 32'(rsp_channel));
      compare_field("average", 32'(w.average), 32'(rsp_average));
      compare_field("last", 32'(w.last), 32'(rsp_last));
      compare_field("accepted", 32'(w.accepted), 32'(rsp_accepted));
      compare_field("started", 32'(w.flags.started), 32'(rsp_started));
      compare_field("sampling", 32'(w.flags.sampling), 32'(rsp_sampling));
      compare_field("too_fast", 32'(w.flags.too_fast), 32'(rsp_too_fast));
      compare_field("unstoppable", 32'(w.flags.unstoppable), 32'(rsp_unstoppable));
      compare_field("overflow", 32'(w.flags.overflow), 32'(rsp_overflow));
      words_checked++;
      if (w.kind) averages_checked++;
   endfunction

   // config, then outgoing check, then prediction of the incoming word
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_words.delete();
         fail_count       = 0;
         words_checked    = 0;
         averages_checked = 0;
      end else begin
         if (csr_we) apply_write(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) check_word();
         if (req_valid && !req_stall)
            predict_words(req_mode, req_conversion_value, req_sample_count, req_buffer_room);
      end
      pending <= expected_words.size();
   end

endmodule

@@ dv/oversampling_adc_scan_averager_unit_tb.sv @@
module oversampling_adc_scan_averager_unit_tb
   import osavg_pkg::*;
;

   localparam int MAX_CH       = 16;
   localparam int MAX_AVG      = 64;
   localparam int WDATA_W      = ($clog2(MAX_CH + 1) > $clog2(MAX_AVG + 1)) ?
                                 $clog2(MAX_CH + 1) : $clog2(MAX_AVG + 1);
   localparam int TARGET_ITEMS = 320;
   localparam int LIMIT        = 400000;
   localparam int QUIET_FROM   = 3000;
   localparam int QUIET_TO     = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 8;

   // indexes past the register list
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [WDATA_W-1:0]    csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_mode = '0;
   logic [SAMPLE_W-1:0]   req_conversion_value = '0;
   logic [COUNT_W-1:0]    req_sample_count = '0;
   logic                  req_buffer_room = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_kind;
   logic [CHAN_W-1:0]     rsp_channel;
   logic [AVG_OUT_W-1:0]  rsp_average;
   logic                  rsp_last;
   logic                  rsp_accepted;
   logic                  rsp_started;
   logic                  rsp_sampling;
   logic                  rsp_too_fast;
   logic                  rsp_unstoppable;
   logic                  rsp_overflow;

   int fail_count;
   int pending;
   int words_checked;
   int averages_checked;

   int  cycle = 0;
   logic hold_go = 1'b0;
   logic hold_seen = 1'b0;
   int  hold_left = 0;
   wire quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

   int total_words = 0;
   int noise_words = 0;
   int settings_used = 0;
   int cur_channels = 1;
   int cur_average = 1;

   oversampling_adc_scan_averager_unit #(
      .MAX_CHANNELS (MAX_CH),
      .MAX_AVERAGE  (MAX_AVG)
   ) u_dut (.*);

   scan_average_checker #(
      .MAX_CH  (MAX_CH),
      .MAX_AVG (MAX_AVG),
      .WDATA_W (WDATA_W)
   ) u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle <= cycle + 1;

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 35);
      end
   end

   initial begin
      while (cycle < LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words still expected", cycle, pending);
      $display("[oversampling_adc_scan_averager_unit] ERROR");
      $finish;
   end

   // offer one word after an optional gap; returns at the accepting edge
   task automatic send_word(input mode_type m, input logic [SAMPLE_W-1:0] v,
                            input logic [COUNT_W-1:0] c, input logic r);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(99) < 35) gap = $urandom_range(4, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_mode             <= m;
      req_conversion_value <= v;
      req_sample_count     <= c;
      req_buffer_room      <= r;
      total_words++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_noise();
      noise_words++;
      send_word(mode_type'($urandom_range(3)), SAMPLE_W'($urandom),
                COUNT_W'($urandom), 1'($urandom));
   endtask

   // stop offering and wait for every expected word
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WDATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_scan(input int cc, input int sa);
      write_reg(REG_CHANNEL_COUNT, WDATA_W'(cc));
      write_reg(REG_SAMPLES_AVG, WDATA_W'(sa));
      cur_channels = cc;
      cur_average  = sa;
      settings_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // start, a few full samples with random content, stop; noise sprinkled in
   task automatic run_sequence(input bit pause_mid);
      int samples;
      int per_sample;
      logic [COUNT_W-1:0] count;
      per_sample = cur_channels * cur_average;
      samples = $urandom_range((per_sample > 16) ? 1 : 3, 1);
      case ($urandom_range(3))
         0:       count = '0;
         1:       count = COUNT_W'($urandom);
         default: count = COUNT_W'(samples);
      endcase
      send_word(MODE_START, pick_sample(), count, 1'($urandom));
      if ($urandom_range(9) == 0) send_word(MODE_START, pick_sample(), COUNT_W'($urandom), 1'b1);
      for (int s = 0; s < samples; s++) begin
         send_word(MODE_TICK, pick_sample(), COUNT_W'($urandom), 1'($urandom));
         if (pause_mid && s == 0) drain_results();
         for (int k = 0; k < per_sample; k++) begin
            if ($urandom_range(99) < 4) send_noise();
            send_word(MODE_CONV, pick_sample(), COUNT_W'($urandom),
                      (k == per_sample - 1) ? ($urandom_range(99) < 85) : 1'($urandom));
         end
      end
      send_word(MODE_STOP, pick_sample(), COUNT_W'($urandom), 1'($urandom));
   endtask

   initial begin
      int phase;
      phase = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle commands, counted run, duplicate start, too-fast tick, overflow
      send_word(MODE_STOP, '0, '0, 1'b0);
      send_word(MODE_TICK, '0, '0, 1'b0);
      send_word(MODE_CONV, '1, '0, 1'b1);
      send_word(MODE_START, '0, 16'd2, 1'b0);
      send_word(MODE_START, '0, '1, 1'b1);
      send_word(MODE_TICK, '0, '0, 1'b1);
      send_word(MODE_CONV, '1, '0, 1'b1);
      send_word(MODE_TICK, '0, '0, 1'b0);
      send_word(MODE_CONV, '0, '1, 1'b1);
      send_word(MODE_START, '0, '0, 1'b1);
      send_word(MODE_TICK, '0, '0, 1'b1);
      send_word(MODE_TICK, '0, '0, 1'b1);
      send_word(MODE_START, '0, 16'd5, 1'b1);
      send_word(MODE_TICK, '0, '0, 1'b1);
      send_word(MODE_CONV, 12'd2048, '0, 1'b0);
      send_word(MODE_START, '1, 16'd1, 1'b0);
      send_word(MODE_STOP, '0, '0, 1'b0);
      send_word(MODE_STOP, '1, '1, 1'b1);
      drain_results();

      // out-of-range values and spare indexes are dropped
      write_reg(REG_CHANNEL_COUNT, '0);
      write_reg(REG_CHANNEL_COUNT, WDATA_W'(MAX_CH + 1));
      write_reg(REG_CHANNEL_COUNT, '1);
      write_reg(REG_SAMPLES_AVG, '0);
      write_reg(REG_SAMPLES_AVG, WDATA_W'(MAX_AVG + 1));
      write_reg(REG_SAMPLES_AVG, '1);
      write_reg(REG_SPARE_LO, WDATA_W'(3));
      write_reg(REG_SPARE_HI, '1);
      set_scan(2, 2);
      send_word(MODE_START, '0, '1, 1'b0);
      send_word(MODE_TICK, '0, '0, 1'b0);
      send_word(MODE_CONV, '1, '0, 1'b0);
      send_word(MODE_CONV, '1, '0, 1'b0);
      send_word(MODE_CONV, 12'd1, '0, 1'b0);
      send_word(MODE_CONV, 12'd2, '0, 1'b1);
      drain_results();

      // writes while armed are dropped
      write_reg(REG_CHANNEL_COUNT, WDATA_W'(5));
      write_reg(REG_SAMPLES_AVG, WDATA_W'(3));
      send_word(MODE_STOP, '0, '0, 1'b0);

      // random phases over several scan settings
      while (total_words < TARGET_ITEMS) begin
         send_word(MODE_STOP, pick_sample(), COUNT_W'($urandom), 1'($urandom));
         drain_results();
         if ($urandom_range(3) == 0) begin
            write_reg(REG_CHANNEL_COUNT, ($urandom_range(1) == 0) ? WDATA_W'(0) :
                      WDATA_W'($urandom_range((1 << WDATA_W) - 1, MAX_CH + 1)));
            write_reg(REG_SAMPLES_AVG, ($urandom_range(1) == 0) ? WDATA_W'(0) :
                      WDATA_W'($urandom_range((1 << WDATA_W) - 1, MAX_AVG + 1)));
            write_reg(($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                      WDATA_W'($urandom));
         end
         case (phase)
            0:       set_scan(MAX_CH, 1);
            1:       set_scan(1, MAX_AVG);
            2:       set_scan(8, 2);
            3:       set_scan($urandom_range(MAX_CH, 1), 1);
            default: set_scan($urandom_range(4, 1), $urandom_range(4, 1));
         endcase
         // long receiver hold-off while the sender keeps offering
         if (phase == 0) hold_go <= 1'b1;
         run_sequence(phase == 4);
         if ($urandom_range(1) == 1) run_sequence(1'b0);
         phase++;
      end
      drain_results();

      $display("sent %0d words (%0d noise) over %0d scan settings in %0d cycles",
               total_words, noise_words, settings_used, cycle);
      $display("checked %0d result words, %0d of them channel averages",
               words_checked, averages_checked);
      if (fail_count == 0) begin
         $display("[oversampling_adc_scan_averager_unit] OK");
      end else begin
         $display("[oversampling_adc_scan_averager_unit] ERROR");
      end
      $finish;
   end

endmodule
